// File: hdl/bblc_pkg.sv
// Package with the shared codes and widths of the byte budget cache directory.
package bblc_pkg;
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 5;
  localparam logic [31:0] BUDGET_RESET = 32'd268435456;

  localparam logic [2:0] OP_GET = 3'd0;
  localparam logic [2:0] OP_PUT = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_TRIM = 3'd4;
  localparam logic [2:0] OP_STATS = 3'd5;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] size;
    logic [31:0] stamp;
    logic [31:0] uses;
  } entry_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction
endpackage

// File: hdl/byte_budget_lru_cache_directory.sv
// Top level of the byte budget LRU cache directory.
// Usage: items (in_op, in_item_tag, in_item_bytes) enter on a valid/ready
// channel; one result leaves per item on the out_ valid/ready channel.
// cfg_we with cfg_wdata writes the byte budget; write it only while idle.
// Entry records live in one synchronous memory of ENTRIES words, read one
// entry per cycle. A tag lookup and an LRU victim search each sweep the
// memory, and each eviction takes one victim search. Get and remove make
// one lookup sweep; clear, statistics reset and unused codes make none;
// trim evicts until the bytes in use fit the budget; a put that fits evicts
// until it fits, looks up its tag and evicts once more if the table is full;
// a put larger than the budget evicts every entry. One item is worked on
// at a time; the next item is accepted the cycle after the result is taken.
// After reset all entries are invalid (valid bits in flip-flops), the
// counters are zero and the budget is 268435456; no clearing pass is needed.
// The result sits in an output register; while the receiver stalls, the
// block holds it and the next item waits until the result is taken.
module byte_budget_lru_cache_directory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_item_tag,
  input  logic [31:0] in_item_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic [3:0]  out_slot,
  output logic [31:0] out_uses,
  output logic [31:0] out_bytes_in_use,
  output logic [4:0]  out_entries_in_use,
  output logic [31:0] out_hits,
  output logic [31:0] out_misses,
  output logic [31:0] out_evictions,
  output logic [4:0]  out_evicted_now,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVSCAN = 3'd1;  // victim search for budget/full/trim
  localparam logic [2:0] ST_LOOK = 3'd2;    // tag lookup sweep
  localparam logic [2:0] ST_FIN = 3'd3;     // write back and result
  localparam logic [2:0] ST_OUT = 3'd4;

  localparam logic [1:0] EV_BUDGET = 2'd0;  // put: evict until fits
  localparam logic [1:0] EV_FULL = 2'd1;    // put: evict when table full
  localparam logic [1:0] EV_TRIM = 2'd2;

  bblc_pkg::entry_t mem [bblc_pkg::ENTRIES];
  bblc_pkg::entry_t rd_q;
  logic we;
  logic [bblc_pkg::IDX_W-1:0] wa, ra;
  bblc_pkg::entry_t wd;

  logic [2:0] state_r, state_nxt;
  logic [1:0] evmode_r, evmode_nxt;
  logic [bblc_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0] budget_r, used_r, used_nxt, clock_r, clock_nxt;
  logic [31:0] hits_r, hits_nxt, miss_r, miss_nxt, evt_r, evt_nxt;
  logic [2:0] op_r, op_nxt;
  logic [31:0] tag_r, tag_nxt, bytes_r, bytes_nxt;
  logic [bblc_pkg::CNT_W-1:0] scan_r, scan_nxt;   // read address counter
  logic rdv_r, rdv_nxt;                           // read data valid
  logic [bblc_pkg::IDX_W-1:0] rdi_r, rdi_nxt;     // index of read data
  logic fnd_r, fnd_nxt;
  logic [bblc_pkg::IDX_W-1:0] fi_r, fi_nxt;
  logic [31:0] fstamp_r, fstamp_nxt, fsize_r, fsize_nxt, fuses_r, fuses_nxt;
  logic [bblc_pkg::CNT_W-1:0] evn_r, evn_nxt;
  logic ovalid_r, ovalid_nxt, ook_r, ook_nxt;
  logic [3:0] oslot_r, oslot_nxt;
  logic [31:0] ouses_r, ouses_nxt;

  logic [bblc_pkg::CNT_W-1:0] cnt;
  logic [bblc_pkg::IDX_W-1:0] free_idx;
  logic [32:0] need;
  logic [32:0] sum_w;
  logic [31:0] used_drop;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  always_comb begin
    cnt = '0;
    free_idx = '0;
    for (int i = bblc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = bblc_pkg::IDX_W'(i);
      end
    end
    for (int i = 0; i < bblc_pkg::ENTRIES; i++) begin
      cnt = cnt + bblc_pkg::CNT_W'(valid_r[i]);
    end
  end

  assign in_ready = (state_r == ST_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_ok = ook_r;
  assign out_slot = oslot_r;
  assign out_uses = ouses_r;
  assign out_bytes_in_use = used_r;
  assign out_entries_in_use = cnt;
  assign out_hits = hits_r;
  assign out_misses = miss_r;
  assign out_evictions = evt_r;
  assign out_evicted_now = evn_r;

  always_comb begin
    need = {1'b0, used_r} + {1'b0, bytes_r};
    sum_w = need;
    used_drop = (fsize_r <= used_r) ? used_r - fsize_r : 32'd0;
  end

  always_comb begin
    state_nxt = state_r;
    evmode_nxt = evmode_r;
    valid_nxt = valid_r;
    used_nxt = used_r;
    clock_nxt = clock_r;
    hits_nxt = hits_r;
    miss_nxt = miss_r;
    evt_nxt = evt_r;
    op_nxt = op_r;
    tag_nxt = tag_r;
    bytes_nxt = bytes_r;
    scan_nxt = scan_r;
    rdv_nxt = 1'b0;
    rdi_nxt = scan_r[bblc_pkg::IDX_W-1:0];
    fnd_nxt = fnd_r;
    fi_nxt = fi_r;
    fstamp_nxt = fstamp_r;
    fsize_nxt = fsize_r;
    fuses_nxt = fuses_r;
    evn_nxt = evn_r;
    ovalid_nxt = ovalid_r;
    ook_nxt = ook_r;
    oslot_nxt = oslot_r;
    ouses_nxt = ouses_r;
    we = 1'b0;
    wa = fi_r;
    wd = '0;
    ra = scan_r[bblc_pkg::IDX_W-1:0];

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_op;
          tag_nxt = in_item_tag;
          bytes_nxt = in_item_bytes;
          evn_nxt = '0;
          scan_nxt = '0;
          fnd_nxt = 1'b0;
          ook_nxt = 1'b0;
          oslot_nxt = '0;
          ouses_nxt = '0;
          unique case (in_op)
            bblc_pkg::OP_GET, bblc_pkg::OP_REMOVE: state_nxt = ST_LOOK;
            bblc_pkg::OP_PUT: begin
              evmode_nxt = EV_BUDGET;
              state_nxt = ST_EVSCAN;
            end
            bblc_pkg::OP_TRIM: begin
              evmode_nxt = EV_TRIM;
              state_nxt = ST_EVSCAN;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end

      ST_EVSCAN: begin
        // At scan start decide whether another eviction is needed.
        if (scan_r == '0 && !rdv_r && !fnd_r) begin
          priority if (cnt == '0) begin
            state_nxt = (evmode_r == EV_BUDGET) ? ST_LOOK : ST_FIN;
          end else if (evmode_r == EV_BUDGET && need <= {1'b0, budget_r}) begin
            state_nxt = ST_LOOK;
          end else if (evmode_r == EV_TRIM && used_r <= budget_r) begin
            state_nxt = ST_FIN;
          end else if (evmode_r == EV_FULL && cnt < bblc_pkg::CNT_W'(bblc_pkg::ENTRIES)) begin
            state_nxt = ST_FIN;
          end else begin
            scan_nxt = scan_r + 1'b1;
            rdv_nxt = 1'b1;
          end
          if (state_nxt != ST_EVSCAN && evmode_r == EV_BUDGET) begin
            scan_nxt = '0;
            fnd_nxt = 1'b0;
            if (bytes_r > budget_r) begin
              state_nxt = ST_FIN;
            end
          end
        end else begin
          if (rdv_r && valid_r[rdi_r] && (!fnd_r || rd_q.stamp < fstamp_r)) begin
            fnd_nxt = 1'b1;
            fi_nxt = rdi_r;
            fstamp_nxt = rd_q.stamp;
            fsize_nxt = rd_q.size;
          end
          if (scan_r < bblc_pkg::CNT_W'(bblc_pkg::ENTRIES)) begin
            scan_nxt = scan_r + 1'b1;
            rdv_nxt = 1'b1;
          end else if (rdv_r) begin
            rdv_nxt = 1'b0;
          end else begin
            // Sweep done: evict the victim.
            valid_nxt[fi_r] = 1'b0;
            used_nxt = used_drop;
            evt_nxt = bblc_pkg::sat_inc(evt_r);
            evn_nxt = evn_r + 1'b1;
            scan_nxt = '0;
            fnd_nxt = 1'b0;
            if (evmode_r == EV_FULL) begin
              state_nxt = ST_FIN;
            end
          end
        end
      end

      ST_LOOK: begin
        if (rdv_r && !fnd_r && valid_r[rdi_r] && rd_q.tag == tag_r) begin
          fnd_nxt = 1'b1;
          fi_nxt = rdi_r;
          fsize_nxt = rd_q.size;
          fuses_nxt = rd_q.uses;
        end
        if (scan_r < bblc_pkg::CNT_W'(bblc_pkg::ENTRIES)) begin
          scan_nxt = scan_r + 1'b1;
          rdv_nxt = 1'b1;
        end else if (rdv_r) begin
          rdv_nxt = 1'b0;
        end else if (op_r == bblc_pkg::OP_PUT) begin
          if (fnd_r) begin
            valid_nxt[fi_r] = 1'b0;
            used_nxt = used_drop;
          end
          evmode_nxt = EV_FULL;
          scan_nxt = '0;
          fnd_nxt = 1'b0;
          state_nxt = ST_EVSCAN;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        unique case (op_r)
          bblc_pkg::OP_GET: begin
            if (fnd_r) begin
              we = 1'b1;
              wd.tag = tag_r;
              wd.size = fsize_r;
              wd.stamp = clock_r;
              wd.uses = bblc_pkg::sat_inc(fuses_r);
              clock_nxt = bblc_pkg::sat_inc(clock_r);
              hits_nxt = bblc_pkg::sat_inc(hits_r);
              ook_nxt = 1'b1;
              oslot_nxt = fi_r;
              ouses_nxt = bblc_pkg::sat_inc(fuses_r);
            end else begin
              miss_nxt = bblc_pkg::sat_inc(miss_r);
            end
          end
          bblc_pkg::OP_PUT: begin
            if (bytes_r <= budget_r && cnt < bblc_pkg::CNT_W'(bblc_pkg::ENTRIES)) begin
              we = 1'b1;
              wa = free_idx;
              wd.tag = tag_r;
              wd.size = bytes_r;
              wd.stamp = clock_r;
              wd.uses = 32'd1;
              valid_nxt[free_idx] = 1'b1;
              clock_nxt = bblc_pkg::sat_inc(clock_r);
              used_nxt = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
              ook_nxt = 1'b1;
              oslot_nxt = free_idx;
              ouses_nxt = 32'd1;
            end
          end
          bblc_pkg::OP_REMOVE: begin
            if (fnd_r) begin
              valid_nxt[fi_r] = 1'b0;
              used_nxt = used_drop;
              ook_nxt = 1'b1;
              oslot_nxt = fi_r;
              ouses_nxt = fuses_r;
            end
          end
          bblc_pkg::OP_CLEAR: begin
            valid_nxt = '0;
            used_nxt = '0;
          end
          bblc_pkg::OP_STATS: begin
            hits_nxt = '0;
            miss_nxt = '0;
            evt_nxt = '0;
          end
          default: ;
        endcase
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        ovalid_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      budget_r <= bblc_pkg::BUDGET_RESET;
      used_r <= '0;
      clock_r <= '0;
      hits_r <= '0;
      miss_r <= '0;
      evt_r <= '0;
      ovalid_r <= 1'b0;
      rdv_r <= 1'b0;
      scan_r <= '0;
      fnd_r <= 1'b0;
      evn_r <= '0;
      evmode_r <= EV_BUDGET;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      budget_r <= cfg_we ? cfg_wdata : budget_r;
      used_r <= used_nxt;
      clock_r <= clock_nxt;
      hits_r <= hits_nxt;
      miss_r <= miss_nxt;
      evt_r <= evt_nxt;
      ovalid_r <= ovalid_nxt;
      rdv_r <= rdv_nxt;
      scan_r <= scan_nxt;
      fnd_r <= fnd_nxt;
      evn_r <= evn_nxt;
      evmode_r <= evmode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    tag_r <= tag_nxt;
    bytes_r <= bytes_nxt;
    rdi_r <= rdi_nxt;
    fi_r <= fi_nxt;
    fstamp_r <= fstamp_nxt;
    fsize_r <= fsize_nxt;
    fuses_r <= fuses_nxt;
    ook_r <= ook_nxt;
    oslot_r <= oslot_nxt;
    ouses_r <= ouses_nxt;
  end
endmodule

// File: tb/tb_byte_budget_lru_cache_directory.sv
// Self-checking testbench of the byte budget LRU cache directory.
module tb_byte_budget_lru_cache_directory;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [31:0] in_item_tag;
  logic [31:0] in_item_bytes;
  logic        out_valid;
  logic        out_ready;
  logic        out_ok;
  logic [3:0]  out_slot;
  logic [31:0] out_uses;
  logic [31:0] out_bytes_in_use;
  logic [4:0]  out_entries_in_use;
  logic [31:0] out_hits;
  logic [31:0] out_misses;
  logic [31:0] out_evictions;
  logic [4:0]  out_evicted_now;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot;
    logic [31:0] uses;
    logic [31:0] bytes_in_use;
    logic [4:0]  entries_in_use;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
    logic [4:0]  evicted_now;
  } lookup_result_t;

  localparam int WATCHDOG_LIMIT = 20000;

  // Shadow copy of the directory.
  logic        dir_valid [bblc_pkg::ENTRIES];
  logic [31:0] dir_tag   [bblc_pkg::ENTRIES];
  logic [31:0] dir_size  [bblc_pkg::ENTRIES];
  logic [31:0] dir_stamp [bblc_pkg::ENTRIES];
  logic [31:0] dir_uses  [bblc_pkg::ENTRIES];
  logic [31:0] dir_budget;
  logic [31:0] dir_bytes;
  logic [31:0] dir_clock;
  logic [31:0] dir_hits;
  logic [31:0] dir_misses;
  logic [31:0] dir_evicts;

  lookup_result_t expected_results[$];
  int  error_count;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off_cycles;
  logic [31:0] recent_tags[8];

  byte_budget_lru_cache_directory uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_item_tag(in_item_tag), .in_item_bytes(in_item_bytes),
    .out_valid(out_valid), .out_ready(out_ready), .out_ok(out_ok),
    .out_slot(out_slot), .out_uses(out_uses), .out_bytes_in_use(out_bytes_in_use),
    .out_entries_in_use(out_entries_in_use), .out_hits(out_hits),
    .out_misses(out_misses), .out_evictions(out_evictions),
    .out_evicted_now(out_evicted_now), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < bblc_pkg::ENTRIES; i++) if (dir_valid[i]) n++;
    return n;
  endfunction

  function automatic int find_entry(input logic [31:0] tag);
    for (int i = 0; i < bblc_pkg::ENTRIES; i++)
      if (dir_valid[i] && dir_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic logic [31:0] next_stamp();
    logic [31:0] s;
    s = dir_clock;
    dir_clock = bump(dir_clock);
    return s;
  endfunction

  function automatic void drop_entry(input int i);
    dir_bytes = (dir_size[i] <= dir_bytes) ? dir_bytes - dir_size[i] : 32'd0;
    dir_valid[i] = 1'b0;
  endfunction

  function automatic int evict_oldest();
    int victim;
    victim = -1;
    for (int i = 0; i < bblc_pkg::ENTRIES; i++)
      if (dir_valid[i] && (victim < 0 || dir_stamp[i] < dir_stamp[victim])) victim = i;
    if (victim < 0) return 0;
    drop_entry(victim);
    dir_evicts = bump(dir_evicts);
    return 1;
  endfunction

  function automatic void reset_directory();
    dir_budget = bblc_pkg::BUDGET_RESET;
    for (int i = 0; i < bblc_pkg::ENTRIES; i++) dir_valid[i] = 1'b0;
    dir_bytes = 0;
    dir_clock = 0;
    dir_hits = 0;
    dir_misses = 0;
    dir_evicts = 0;
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [2:0] op,
      input logic [31:0] tag, input logic [31:0] nbytes);
    lookup_result_t r;
    int i;
    int evicted;
    logic [32:0] sum;
    r = '0;
    evicted = 0;
    case (op)
      bblc_pkg::OP_GET: begin
        i = find_entry(tag);
        if (i >= 0) begin
          dir_stamp[i] = next_stamp();
          dir_uses[i] = bump(dir_uses[i]);
          dir_hits = bump(dir_hits);
          r.ok = 1'b1;
          r.slot = i[3:0];
          r.uses = dir_uses[i];
        end else begin
          dir_misses = bump(dir_misses);
        end
      end
      bblc_pkg::OP_PUT: begin
        while ({1'b0, dir_bytes} + {1'b0, nbytes} > {1'b0, dir_budget} && live_count() > 0)
          evicted += evict_oldest();
        if (nbytes <= dir_budget) begin
          i = find_entry(tag);
          if (i >= 0) drop_entry(i);
          if (live_count() >= bblc_pkg::ENTRIES) evicted += evict_oldest();
          i = -1;
          for (int k = bblc_pkg::ENTRIES - 1; k >= 0; k--) if (!dir_valid[k]) i = k;
          if (i >= 0) begin
            dir_valid[i] = 1'b1;
            dir_tag[i] = tag;
            dir_size[i] = nbytes;
            dir_stamp[i] = next_stamp();
            dir_uses[i] = 32'd1;
            sum = {1'b0, dir_bytes} + {1'b0, nbytes};
            dir_bytes = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r.ok = 1'b1;
            r.slot = i[3:0];
            r.uses = 32'd1;
          end
        end
      end
      bblc_pkg::OP_REMOVE: begin
        i = find_entry(tag);
        if (i >= 0) begin
          r.ok = 1'b1;
          r.slot = i[3:0];
          r.uses = dir_uses[i];
          drop_entry(i);
        end
      end
      bblc_pkg::OP_CLEAR: begin
        for (int k = 0; k < bblc_pkg::ENTRIES; k++) dir_valid[k] = 1'b0;
        dir_bytes = 0;
      end
      bblc_pkg::OP_TRIM: begin
        while (dir_bytes > dir_budget && live_count() > 0) evicted += evict_oldest();
      end
      bblc_pkg::OP_STATS: begin
        dir_hits = 0;
        dir_misses = 0;
        dir_evicts = 0;
      end
      default: ;
    endcase
    r.bytes_in_use = dir_bytes;
    r.entries_in_use = 5'(live_count());
    r.hits = dir_hits;
    r.misses = dir_misses;
    r.evictions = dir_evicts;
    r.evicted_now = evicted[4:0];
    return r;
  endfunction

  // Sends one item; the prediction is made when it is accepted.
  // Valid stays high into the next item unless the sender idles first.
  task automatic send_item(input logic [2:0] op, input logic [31:0] tag,
      input logic [31:0] nbytes);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_item_tag <= tag;
    in_item_bytes <= nbytes;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_lookup(op, tag, nbytes));
    recent_tags[$urandom_range(7)] = tag;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_budget(input logic [31:0] value);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    dir_budget = value;
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    lookup_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_ok, out_slot, out_uses, out_bytes_in_use, out_entries_in_use,
              out_hits, out_misses, out_evictions, out_evicted_now};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.ok != want.ok) begin
          $display("%0t: ok exp %h got %h", $time, want.ok, got.ok); error_count++;
        end
        if (got.slot != want.slot) begin
          $display("%0t: slot exp %h got %h", $time, want.slot, got.slot); error_count++;
        end
        if (got.uses != want.uses) begin
          $display("%0t: uses exp %h got %h", $time, want.uses, got.uses); error_count++;
        end
        if (got.bytes_in_use != want.bytes_in_use) begin
          $display("%0t: bytes_in_use exp %h got %h", $time, want.bytes_in_use,
                   got.bytes_in_use);
          error_count++;
        end
        if (got.entries_in_use != want.entries_in_use) begin
          $display("%0t: entries_in_use exp %h got %h", $time, want.entries_in_use,
                   got.entries_in_use);
          error_count++;
        end
        if (got.hits != want.hits) begin
          $display("%0t: hits exp %h got %h", $time, want.hits, got.hits); error_count++;
        end
        if (got.misses != want.misses) begin
          $display("%0t: misses exp %h got %h", $time, want.misses, got.misses);
          error_count++;
        end
        if (got.evictions != want.evictions) begin
          $display("%0t: evictions exp %h got %h", $time, want.evictions, got.evictions);
          error_count++;
        end
        if (got.evicted_now != want.evicted_now) begin
          $display("%0t: evicted_now exp %h got %h", $time, want.evicted_now,
                   got.evicted_now);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_item(bblc_pkg::OP_GET, 32'h0, 32'h0);
    send_item(bblc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0);
    send_item(bblc_pkg::OP_PUT, 32'h0, 32'h1000_0000);
    send_item(bblc_pkg::OP_PUT, 32'h1, 32'h1);
    send_item(bblc_pkg::OP_PUT, 32'h2, 32'hFFFF_FFFF);
    send_item(bblc_pkg::OP_PUT, 32'h3, 32'h10);
    send_item(bblc_pkg::OP_PUT, 32'h3, 32'h20);
    send_item(bblc_pkg::OP_GET, 32'h3, 32'h0);
    send_item(bblc_pkg::OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bblc_pkg::OP_REMOVE, 32'h3, 32'h0);
    send_item(bblc_pkg::OP_REMOVE, 32'h3, 32'h0);
    for (int i = 0; i < 17; i++) send_item(bblc_pkg::OP_PUT, 32'hA000 + i, 32'h4);
    send_item(bblc_pkg::OP_TRIM, 32'h0, 32'h0);
    send_item(bblc_pkg::OP_STATS, 32'h0, 32'h0);
    send_item(3'd6, 32'h5, 32'h5);
    send_item(3'd7, 32'h5, 32'h5);
    send_item(bblc_pkg::OP_CLEAR, 32'h0, 32'h0);
  endtask

  // Budget extremes: zero, all ones with byte totals at the top of the range, then a trim.
  task automatic test_budget_extremes();
    write_budget(32'h0);
    send_item(bblc_pkg::OP_PUT, 32'h11, 32'h0);
    send_item(bblc_pkg::OP_PUT, 32'h12, 32'h1);
    write_budget(32'hFFFF_FFFF);
    send_item(bblc_pkg::OP_PUT, 32'h13, 32'hFFFF_FFF0);
    send_item(bblc_pkg::OP_PUT, 32'h14, 32'hFFFF_FFFF);
    send_item(bblc_pkg::OP_PUT, 32'h15, 32'h20);
    write_budget(32'h100);
    send_item(bblc_pkg::OP_TRIM, 32'h0, 32'h0);
    send_item(bblc_pkg::OP_CLEAR, 32'h0, 32'h0);
  endtask

  task automatic test_random(input int count);
    logic [2:0]  op;
    logic [31:0] tag;
    logic [31:0] nbytes;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = bblc_pkg::OP_PUT;
      else if (pick < 75) op = bblc_pkg::OP_GET;
      else if (pick < 87) op = bblc_pkg::OP_REMOVE;
      else if (pick < 92) op = bblc_pkg::OP_TRIM;
      else if (pick < 94) op = bblc_pkg::OP_CLEAR;
      else if (pick < 97) op = bblc_pkg::OP_STATS;
      else op = 3'($urandom_range(7));
      tag = ($urandom_range(9) < 7) ? recent_tags[$urandom_range(7)]
          : ($urandom_range(1) ? $urandom() : $urandom_range(31));
      pick = $urandom_range(9);
      nbytes = (pick < 7) ? $urandom_range(300) : (pick < 9 ? $urandom() : 32'hFFFF_FFFF);
      send_item(op, tag, nbytes);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = bblc_pkg::OP_GET;
    in_item_tag = '0;
    in_item_bytes = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    error_count = 0;
    hold_off_cycles = 0;
    send_idle_pct = 10;
    recv_idle_pct = 67;
    for (int i = 0; i < 8; i++) recent_tags[i] = i;
    reset_directory();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_budget_extremes();
    write_budget(32'd1000);
    test_random(450);
    send_idle_pct = 67;
    recv_idle_pct = 10;
    write_budget(32'd400);
    // Long receiver stall while items keep coming.
    hold_off_cycles = 400;
    test_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_budget(32'hFFFF_FFFF);
    test_random(200);
    write_budget(32'd2500);
    test_random(300);

    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
